// File: rtl/tobm_pkg.sv
package tobm_pkg;

	// Default field widths
	localparam int PRICE_BITS_DEF = 32;
	localparam int SIZE_BITS_DEF  = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Result status codes; the failing ones are in priority order, highest first
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_CROSSED   = 2'd2,
		STAT_ZERO_SIZE = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_MP_GO,
		S_MP_RUN,
		S_IMB_GO,
		S_IMB_RUN,
		S_FIN
	} state_t;

	// Request from the sequencer to the shared divider
	typedef struct packed {
		logic start;
		logic short_run;
	} div_req_t;

endpackage

// File: rtl/tobm_div.sv
module tobm_div #(
	parameter int PRICE_BITS = tobm_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS  = tobm_pkg::SIZE_BITS_DEF,
	parameter int FRAC_BITS  = tobm_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tobm_pkg::div_req_t              req,
	input  logic [SIZE_BITS:0]              den,
	input  logic [SIZE_BITS:0]              rem_init,
	input  logic [PRICE_BITS+FRAC_BITS-1:0] bits,
	output logic                            busy,
	output logic [PRICE_BITS+FRAC_BITS-1:0] quo
);
	import tobm_pkg::*;

	localparam int Q_W   = PRICE_BITS + FRAC_BITS;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SIZE_BITS:0] rem_q;
	logic [Q_W-1:0]     bits_q;
	logic [Q_W-1:0]     quo_q;

	logic [SIZE_BITS+1:0] rem_sh;
	logic [SIZE_BITS+1:0] rem_sub;
	logic                 ge;
	logic [SIZE_BITS:0]   rem_nx;

	// One restoring step: shift in the next numerator bit, subtract if it fits
	assign rem_sh  = {rem_q, bits_q[Q_W-1]};
	assign rem_sub = rem_sh - {1'b0, den};
	assign ge      = (rem_sh >= {1'b0, den});
	assign rem_nx  = ge ? rem_sub[SIZE_BITS:0] : rem_sh[SIZE_BITS:0];

	// Step counter and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.short_run ? CNT_W'(FRAC_BITS + 1) : CNT_W'(Q_W);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CNT_W'(1));
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

	// Partial remainder, numerator bits and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= rem_init;
			bits_q <= bits;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			bits_q <= {bits_q[Q_W-2:0], 1'b0};
			quo_q  <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

// File: rtl/top_of_book_metrics_core.sv
// Channel  Dir  Signals                    Contents (lowest bit up)
// s        in   tvalid tready tdata tuser  tdata: level_price, level_size; tuser: func;
//                     tlast                 tlast: snapshot_end
// m        out  tvalid tready tdata tuser  tdata: best levels, mid_twice, spread,
//                                           microprice, imbalance; tuser: status
//
// A level that does not end a snapshot leaves the sequencer idle; the next word is taken right after.
// A snapshot end with a failing status goes through accept, evaluate and load result.
// A snapshot end with an ok status adds a multiply and then two runs of the shared
// one-bit-per-cycle divider: PRICE_BITS+FRAC_BITS steps for the microprice, then
// FRAC_BITS+1 steps for the imbalance, before the result is loaded.
// Reset clears the kept best levels and the sequencer. A result waiting on m_tready
// holds in the output register; new levels are still taken meanwhile, and the next
// result loads once the register is free.
module top_of_book_metrics_core #(
	parameter int PRICE_BITS = tobm_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS  = tobm_pkg::SIZE_BITS_DEF,
	parameter int FRAC_BITS  = tobm_pkg::FRAC_BITS_DEF,
	localparam int IN_W      = ((PRICE_BITS + SIZE_BITS + 7) / 8) * 8,
	localparam int MICRO_W   = (PRICE_BITS + FRAC_BITS > 64) ? 64 : PRICE_BITS + FRAC_BITS,
	localparam int OUT_RAW   = 4 * PRICE_BITS + 2 * SIZE_BITS + 1 + MICRO_W + FRAC_BITS + 2,
	localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,  // level_price, level_size
	input  logic              s_tuser,  // func
	input  logic              s_tlast,  // snapshot_end
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_W-1:0]  m_tdata,  // best_bid_price, best_bid_size, best_ask_price,
	                                    // best_ask_size, mid_twice, spread, microprice,
	                                    // imbalance
	output logic [1:0]        m_tuser   // status
);
	import tobm_pkg::*;

	localparam int Q_W   = PRICE_BITS + FRAC_BITS;
	localparam int IMB_W = FRAC_BITS + 2;

	state_t state_q, state_nx;

	logic                  bid_seen_q, ask_seen_q;
	logic [PRICE_BITS-1:0] top_bid_price_q, top_ask_price_q;
	logic [SIZE_BITS-1:0]  top_bid_size_q, top_ask_size_q;

	status_t                       status_q;
	logic [PRICE_BITS-1:0]         spread_q;
	logic [SIZE_BITS:0]            total_q;
	logic [SIZE_BITS-1:0]          diff_q;
	logic                          neg_q;
	logic [PRICE_BITS+SIZE_BITS-1:0] prod_q;
	logic [MICRO_W-1:0]            micro_q;
	logic [IMB_W-1:0]              imb_q;

	logic                  m_tvalid_q;
	logic [OUT_W-1:0]      m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic                  s_fire, out_free, load_out;
	logic [PRICE_BITS-1:0] in_price;
	logic [SIZE_BITS-1:0]  in_size;
	logic                  upd_bid, upd_ask;
	status_t               status_nx;

	div_req_t              div_req;
	logic [SIZE_BITS:0]    div_rem_init;
	logic [Q_W-1:0]        div_bits;
	logic                  div_busy;
	logic [Q_W-1:0]        div_quo;

	logic [Q_W-1:0]        micro_sum;
	logic [IMB_W-1:0]      imb_mag;
	logic [OUT_RAW-1:0]    out_raw;

	assign in_price = s_tdata[PRICE_BITS-1:0];
	assign in_size  = s_tdata[PRICE_BITS+SIZE_BITS-1:PRICE_BITS];
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// Running best: a later level at an equal price does not replace the kept one
	assign upd_bid = !s_tuser && (!bid_seen_q || in_price > top_bid_price_q);
	assign upd_ask = s_tuser && (!ask_seen_q || in_price < top_ask_price_q);

	// Status from the kept levels, in priority order
	always_comb begin
		if (!bid_seen_q || !ask_seen_q) begin
			status_nx = STAT_EMPTY;
		end else if (top_ask_price_q <= top_bid_price_q) begin
			status_nx = STAT_CROSSED;
		end else if (top_bid_size_q == '0 || top_ask_size_q == '0) begin
			status_nx = STAT_ZERO_SIZE;
		end else begin
			status_nx = STAT_OK;
		end
	end

	// Sequencer: next state and divider requests
	always_comb begin
		state_nx          = state_q;
		s_tready          = 1'b0;
		load_out          = 1'b0;
		div_req.start     = 1'b0;
		div_req.short_run = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				state_nx = (status_nx == STAT_OK) ? S_MUL : S_FIN;
			end
			S_MUL: begin
				state_nx = S_MP_GO;
			end
			S_MP_GO: begin
				div_req.start = 1'b1;
				state_nx      = S_MP_RUN;
			end
			S_MP_RUN: begin
				if (!div_busy) begin
					state_nx = S_IMB_GO;
				end
			end
			S_IMB_GO: begin
				div_req.start     = 1'b1;
				div_req.short_run = 1'b1;
				state_nx          = S_IMB_RUN;
			end
			S_IMB_RUN: begin
				if (!div_busy) begin
					state_nx = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Kept best levels: fold in accepted words, clear once the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bid_seen_q      <= 1'b0;
			ask_seen_q      <= 1'b0;
			top_bid_price_q <= '0;
			top_bid_size_q  <= '0;
			top_ask_price_q <= '0;
			top_ask_size_q  <= '0;
		end else if (load_out) begin
			bid_seen_q      <= 1'b0;
			ask_seen_q      <= 1'b0;
			top_bid_price_q <= '0;
			top_bid_size_q  <= '0;
			top_ask_price_q <= '0;
			top_ask_size_q  <= '0;
		end else if (s_fire) begin
			if (upd_bid) begin
				bid_seen_q      <= 1'b1;
				top_bid_price_q <= in_price;
				top_bid_size_q  <= in_size;
			end
			if (upd_ask) begin
				ask_seen_q      <= 1'b1;
				top_ask_price_q <= in_price;
				top_ask_size_q  <= in_size;
			end
		end
	end

	// Working registers of the metric computation
	assign micro_sum = {top_bid_price_q, {FRAC_BITS{1'b0}}} + div_quo;
	assign imb_mag   = {1'b0, div_quo[FRAC_BITS:0]};

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			status_q <= status_nx;
			spread_q <= top_ask_price_q - top_bid_price_q;
			total_q  <= {1'b0, top_bid_size_q} + {1'b0, top_ask_size_q};
			neg_q    <= (top_bid_size_q < top_ask_size_q);
			diff_q   <= (top_bid_size_q < top_ask_size_q) ?
				top_ask_size_q - top_bid_size_q : top_bid_size_q - top_ask_size_q;
			micro_q  <= '0;
			imb_q    <= '0;
		end
		if (state_q == S_MUL) begin
			prod_q <= (PRICE_BITS+SIZE_BITS)'(spread_q) * (PRICE_BITS+SIZE_BITS)'(top_bid_size_q);
		end
		if (state_q == S_MP_RUN && !div_busy) begin
			micro_q <= micro_sum[MICRO_W-1:0];
		end
		if (state_q == S_IMB_RUN && !div_busy) begin
			imb_q <= neg_q ? (IMB_W'(0) - imb_mag) : imb_mag;
		end
	end

	// Divider operands: the high part of the numerator seeds the remainder
	always_comb begin
		if (state_q == S_IMB_GO) begin
			div_rem_init = {2'b00, diff_q[SIZE_BITS-1:1]};
			div_bits     = {diff_q[0], {(Q_W-1){1'b0}}};
		end else begin
			div_rem_init = {1'b0, prod_q[PRICE_BITS+SIZE_BITS-1:PRICE_BITS]};
			div_bits     = {prod_q[PRICE_BITS-1:0], {FRAC_BITS{1'b0}}};
		end
	end

	tobm_div #(
		.PRICE_BITS (PRICE_BITS),
		.SIZE_BITS  (SIZE_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.den      (total_q),
		.rem_init (div_rem_init),
		.bits     (div_bits),
		.busy     (div_busy),
		.quo      (div_quo)
	);

	// Pack the result word
	assign out_raw = {
		imb_q,
		micro_q,
		spread_q & {PRICE_BITS{status_q == STAT_OK}},
		{1'b0, top_bid_price_q} + {1'b0, top_ask_price_q},
		top_ask_size_q,
		top_ask_price_q,
		top_bid_size_q,
		top_bid_price_q
	};

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= OUT_W'(out_raw);
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/tobm_checker.sv
module tobm_checker #(
	parameter int PRICE_BITS = tobm_pkg::PRICE_BITS_DEF,
	parameter int SIZE_BITS  = tobm_pkg::SIZE_BITS_DEF,
	parameter int FRAC_BITS  = tobm_pkg::FRAC_BITS_DEF,
	localparam int IN_W      = ((PRICE_BITS + SIZE_BITS + 7) / 8) * 8,
	localparam int MICRO_W   = (PRICE_BITS + FRAC_BITS > 64) ? 64 : PRICE_BITS + FRAC_BITS,
	localparam int OUT_RAW   = 4 * PRICE_BITS + 2 * SIZE_BITS + 1 + MICRO_W + FRAC_BITS + 2,
	localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [IN_W-1:0]  s_tdata,  // level_price, level_size
	input logic             s_tuser,  // func
	input logic             s_tlast,  // snapshot_end
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,  // best levels, mid_twice, spread, microprice, imbalance
	input logic [1:0]       m_tuser   // status
);
	import tobm_pkg::*;

	localparam int O_BAP = PRICE_BITS + SIZE_BITS;
	localparam int O_MID = 2 * PRICE_BITS + 2 * SIZE_BITS;
	localparam int O_SPR = O_MID + PRICE_BITS + 1;
	localparam int O_MIC = O_SPR + PRICE_BITS;

	logic [PRICE_BITS-1:0] bid_px, ask_px, spread;
	logic [PRICE_BITS:0]   mid;
	logic [OUT_RAW-O_SPR-1:0] metrics;
	logic                  ok;

	assign bid_px  = m_tdata[PRICE_BITS-1:0];
	assign ask_px  = m_tdata[O_BAP+PRICE_BITS-1:O_BAP];
	assign mid     = m_tdata[O_SPR-1:O_MID];
	assign spread  = m_tdata[O_MIC-1:O_SPR];
	assign metrics = m_tdata[OUT_RAW-1:O_SPR];
	assign ok      = (m_tuser == STAT_OK);

	// An ok result has an uncrossed book and a spread that matches it
	a_ok_spread: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ok |-> (ask_px > bid_px) && (spread == ask_px - bid_px))
		else $error("ok result with crossed book or wrong spread");

	// A failed status zeroes spread, microprice and imbalance
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ok |-> (metrics == '0))
		else $error("failed status with nonzero metrics");

	// Twice the mid is always the sum of the best prices
	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (mid == {1'b0, bid_px} + {1'b0, ask_px}))
		else $error("mid_twice does not match best prices");

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

endmodule

bind top_of_book_metrics_core tobm_checker #(
	.PRICE_BITS (PRICE_BITS),
	.SIZE_BITS  (SIZE_BITS),
	.FRAC_BITS  (FRAC_BITS)
) u_tobm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
